FILE: hw/rtl/hcice_pkg.sv
// ----------------------------------------------------------------------------
// hcice_pkg
// Shared codes, job record and parser phases for the HCI command/event engine.
// ----------------------------------------------------------------------------
package hcice_pkg;

  localparam logic [1:0] MODE_START   = 2'd0;
  localparam logic [1:0] MODE_PAYLOAD = 2'd1;
  localparam logic [1:0] MODE_RX      = 2'd2;

  localparam logic [1:0] KIND_TX   = 2'd0;
  localparam logic [1:0] KIND_RET  = 2'd1;
  localparam logic [1:0] KIND_DONE = 2'd2;

  localparam logic [7:0] PKT_COMMAND  = 8'h01;
  localparam logic [7:0] PKT_EVENT    = 8'h04;
  localparam logic [7:0] EVT_COMPLETE = 8'h0E;
  localparam logic [7:0] EVT_STATUS   = 8'h0F;
  localparam logic [7:0] CS_LEN       = 8'h04;

  localparam logic [3:0] ST_OK          = 4'd0;
  localparam logic [3:0] ST_BAD_TYPE    = 4'd1;
  localparam logic [3:0] ST_CS_LEN      = 4'd2;
  localparam logic [3:0] ST_CS_STATUS   = 4'd3;
  localparam logic [3:0] ST_CS_NUM      = 4'd4;
  localparam logic [3:0] ST_CS_OPL      = 4'd5;
  localparam logic [3:0] ST_CS_OPH      = 4'd6;
  localparam logic [3:0] ST_CC_LEN      = 4'd7;
  localparam logic [3:0] ST_CC_NUM      = 4'd8;
  localparam logic [3:0] ST_CC_OPL      = 4'd9;
  localparam logic [3:0] ST_CC_OPH      = 4'd10;
  localparam logic [3:0] ST_CC_STATUS   = 4'd11;
  localparam logic [3:0] ST_BAD_EVENT   = 4'd12;

  localparam int QDEPTH = 4;
  localparam int QAW    = $clog2(QDEPTH);

  // Work handed from the front to the back; each op expands to 1..4 results.
  typedef enum logic [2:0] {
    JOB_HDR     = 3'd0,
    JOB_TX      = 3'd1,
    JOB_RET     = 3'd2,
    JOB_RET_FIN = 3'd3,
    JOB_FIN     = 3'd4
  } job_op_t;

  typedef struct packed {
    job_op_t    op;
    logic [7:0] b0;
    logic [7:0] b1;
    logic [7:0] b2;
    logic [3:0] code;
  } job_t;

  typedef enum logic [14:0] {
    PH_IDLE   = 15'b000000000000001,
    PH_SEND   = 15'b000000000000010,
    PH_TYPE   = 15'b000000000000100,
    PH_CODE   = 15'b000000000001000,
    PH_S_LEN  = 15'b000000000010000,
    PH_S_STAT = 15'b000000000100000,
    PH_S_NUM  = 15'b000000001000000,
    PH_S_OPL  = 15'b000000010000000,
    PH_S_OPH  = 15'b000000100000000,
    PH_C_LEN  = 15'b000001000000000,
    PH_C_NUM  = 15'b000010000000000,
    PH_C_OPL  = 15'b000100000000000,
    PH_C_OPH  = 15'b001000000000000,
    PH_C_STAT = 15'b010000000000000,
    PH_C_RET  = 15'b100000000000000
  } phase_t;

endpackage

FILE: hw/rtl/hcice_if.sv
// ----------------------------------------------------------------------------
// hcice_if
// Valid/ready channels for requests into and results out of the engine.
// ----------------------------------------------------------------------------
interface hcice_req_if;
  logic       valid;
  logic       ready;
  logic [1:0] mode;
  logic [15:0] opcode;
  logic [7:0] param_len;
  logic [7:0] return_len;
  logic [7:0] data_byte;

  modport source (output valid, mode, opcode, param_len, return_len, data_byte,
                  input ready);
  modport sink   (input valid, mode, opcode, param_len, return_len, data_byte,
                  output ready);
endinterface

interface hcice_res_if;
  logic       valid;
  logic       ready;
  logic [1:0] kind;
  logic [7:0] out_byte;
  logic [3:0] status_code;
  logic       last;

  modport source (output valid, kind, out_byte, status_code, last, input ready);
  modport sink   (input valid, kind, out_byte, status_code, last, output ready);
endinterface

FILE: hw/rtl/hci_command_event_engine_top.sv
// ----------------------------------------------------------------------------
// hci_command_event_engine_top
// HCI command framer and Command Status / Command Complete reply checker.
// ----------------------------------------------------------------------------
// One request is taken per cycle while the four-entry job queue has room.
// Its first result, if any, goes through the job queue, then the output register.
// Payload bytes, return bytes and bytes that end a command each give one result.
// Other received bytes give none. These stream at one per cycle unless stalled.
// A start request gives four transmit bytes. The final return byte gives the
// byte plus the finish result. These leave the single output register one per
// cycle while it is not stalled, so a start holds the output for all four bytes
// and the queue absorbs the requests behind it.
// Received bytes while idle or while payload is still owed are dropped.
module hci_command_event_engine_top (
  input  logic        clk,
  input  logic        rst,
  hcice_req_if.sink   req,
  hcice_res_if.source res
);
  import hcice_pkg::*;

  logic  job_valid, job_ready;
  job_t  job;
  logic  head_valid, pop;
  job_t  head_job;

  hcice_front u_front (
    .clk       (clk),
    .rst       (rst),
    .req       (req),
    .job_valid (job_valid),
    .job       (job),
    .job_ready (job_ready)
  );

  hcice_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (job_valid),
    .push_job   (job),
    .push_ready (job_ready),
    .head_valid (head_valid),
    .head_job   (head_job),
    .pop        (pop)
  );

  hcice_back u_back (
    .clk        (clk),
    .rst        (rst),
    .head_valid (head_valid),
    .head_job   (head_job),
    .pop        (pop),
    .res        (res)
  );

endmodule

FILE: hw/rtl/hcice_front.sv
// ----------------------------------------------------------------------------
// hcice_front
// Accepts requests, tracks framing and event-parse phase, issues jobs.
// ----------------------------------------------------------------------------
module hcice_front (
  input  logic             clk,
  input  logic             rst,
  hcice_req_if.sink        req,
  output logic             job_valid,
  output hcice_pkg::job_t  job,
  input  logic             job_ready
);
  import hcice_pkg::*;

  phase_t      phase, phase_next;
  logic [15:0] saved_opcode, saved_opcode_next;
  logic [7:0]  payload_left, payload_left_next;
  logic [7:0]  expected_return, expected_return_next;
  logic [7:0]  return_left, return_left_next;

  logic       accept;
  logic [7:0] b;
  logic [7:0] lo, hi;
  logic [7:0] pl_dec, rl_dec;
  logic       cc_len_ok;

  assign req.ready = job_ready;
  assign accept    = req.valid && req.ready;
  assign b         = req.data_byte;
  assign lo        = saved_opcode[7:0];
  assign hi        = saved_opcode[15:8];
  assign pl_dec    = payload_left - 8'd1;
  assign rl_dec    = return_left - 8'd1;
  assign cc_len_ok = {1'b0, b} == ({1'b0, CS_LEN} + {1'b0, expected_return});

  always_comb begin
    phase_next           = phase;
    saved_opcode_next    = saved_opcode;
    payload_left_next    = payload_left;
    expected_return_next = expected_return;
    return_left_next     = return_left;
    job_valid            = 1'b0;
    job                  = '{op: JOB_FIN, b0: 8'd0, b1: 8'd0, b2: 8'd0, code: ST_OK};
    if (accept) begin
      unique case (req.mode)
        MODE_START: begin
          saved_opcode_next    = req.opcode;
          payload_left_next    = req.param_len;
          expected_return_next = req.return_len;
          return_left_next     = 8'd0;
          job_valid            = 1'b1;
          job.op               = JOB_HDR;
          job.b0               = req.opcode[7:0];
          job.b1               = req.opcode[15:8];
          job.b2               = req.param_len;
          phase_next           = (req.param_len != 8'd0) ? PH_SEND : PH_TYPE;
        end
        MODE_PAYLOAD: begin
          if (phase == PH_SEND) begin
            job_valid         = 1'b1;
            job.op            = JOB_TX;
            job.b0            = b;
            payload_left_next = pl_dec;
            if (pl_dec == 8'd0) phase_next = PH_TYPE;
          end
        end
        MODE_RX: begin
          unique case (phase)
            PH_TYPE: begin
              if (b != PKT_EVENT) begin
                job_valid = 1'b1; job.code = ST_BAD_TYPE; phase_next = PH_IDLE;
              end else phase_next = PH_CODE;
            end
            PH_CODE: begin
              if (b == EVT_STATUS) phase_next = PH_S_LEN;
              else if (b == EVT_COMPLETE) phase_next = PH_C_LEN;
              else begin
                job_valid = 1'b1; job.code = ST_BAD_EVENT; phase_next = PH_IDLE;
              end
            end
            PH_S_LEN: begin
              if (b != CS_LEN) begin
                job_valid = 1'b1; job.code = ST_CS_LEN; phase_next = PH_IDLE;
              end else phase_next = PH_S_STAT;
            end
            PH_S_STAT: begin
              if (b != 8'd0) begin
                job_valid = 1'b1; job.code = ST_CS_STATUS; phase_next = PH_IDLE;
              end else phase_next = PH_S_NUM;
            end
            PH_S_NUM: begin
              if (b == 8'd0) begin
                job_valid = 1'b1; job.code = ST_CS_NUM; phase_next = PH_IDLE;
              end else phase_next = PH_S_OPL;
            end
            PH_S_OPL: begin
              if (b != lo) begin
                job_valid = 1'b1; job.code = ST_CS_OPL; phase_next = PH_IDLE;
              end else phase_next = PH_S_OPH;
            end
            PH_S_OPH: begin
              job_valid  = 1'b1;
              job.code   = (b != hi) ? ST_CS_OPH : ST_OK;
              phase_next = PH_IDLE;
            end
            PH_C_LEN: begin
              if (!cc_len_ok) begin
                job_valid = 1'b1; job.code = ST_CC_LEN; phase_next = PH_IDLE;
              end else phase_next = PH_C_NUM;
            end
            PH_C_NUM: begin
              if (b == 8'd0) begin
                job_valid = 1'b1; job.code = ST_CC_NUM; phase_next = PH_IDLE;
              end else phase_next = PH_C_OPL;
            end
            PH_C_OPL: begin
              if (b != lo) begin
                job_valid = 1'b1; job.code = ST_CC_OPL; phase_next = PH_IDLE;
              end else phase_next = PH_C_OPH;
            end
            PH_C_OPH: begin
              if (b != hi) begin
                job_valid = 1'b1; job.code = ST_CC_OPH; phase_next = PH_IDLE;
              end else phase_next = PH_C_STAT;
            end
            PH_C_STAT: begin
              if (b != 8'd0) begin
                job_valid = 1'b1; job.code = ST_CC_STATUS; phase_next = PH_IDLE;
              end else if (expected_return == 8'd0) begin
                job_valid = 1'b1; job.code = ST_OK; phase_next = PH_IDLE;
              end else begin
                return_left_next = expected_return;
                phase_next       = PH_C_RET;
              end
            end
            PH_C_RET: begin
              job_valid        = 1'b1;
              job.b0           = b;
              return_left_next = rl_dec;
              if (rl_dec == 8'd0) begin
                job.op     = JOB_RET_FIN;
                phase_next = PH_IDLE;
              end else job.op = JOB_RET;
            end
            default: ;
          endcase
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase           <= PH_IDLE;
      saved_opcode    <= '0;
      payload_left    <= '0;
      expected_return <= '0;
      return_left     <= '0;
    end else begin
      phase           <= phase_next;
      saved_opcode    <= saved_opcode_next;
      payload_left    <= payload_left_next;
      expected_return <= expected_return_next;
      return_left     <= return_left_next;
    end
  end

endmodule

FILE: hw/rtl/hcice_queue.sv
// ----------------------------------------------------------------------------
// hcice_queue
// Small job FIFO between front and back.
// ----------------------------------------------------------------------------
module hcice_queue (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  hcice_pkg::job_t  push_job,
  output logic             push_ready,
  output logic             head_valid,
  output hcice_pkg::job_t  head_job,
  input  logic             pop
);
  import hcice_pkg::*;

  job_t           mem [QDEPTH];
  logic [QAW-1:0] wr_ptr, rd_ptr;
  logic [QAW:0]   count;
  logic           do_push, do_pop;

  assign push_ready = count != (QAW+1)'(QDEPTH);
  assign head_valid = count != '0;
  assign head_job   = mem[rd_ptr];
  assign do_push    = push && push_ready;
  assign do_pop     = pop && head_valid;

  always_ff @(posedge clk) begin
    if (do_push) mem[wr_ptr] <= push_job;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) wr_ptr <= wr_ptr + 1'b1;
      if (do_pop)  rd_ptr <= rd_ptr + 1'b1;
      count <= count + (QAW+1)'(do_push) - (QAW+1)'(do_pop);
    end
  end

endmodule

FILE: hw/rtl/hcice_back.sv
// ----------------------------------------------------------------------------
// hcice_back
// Expands queued jobs into result items through one output register.
// ----------------------------------------------------------------------------
module hcice_back (
  input  logic             clk,
  input  logic             rst,
  input  logic             head_valid,
  input  hcice_pkg::job_t  head_job,
  output logic             pop,
  hcice_res_if.source      res
);
  import hcice_pkg::*;

  logic [1:0] cnt;
  logic [1:0] n_last;
  logic       load, take, is_last;
  logic [1:0] kind_c;
  logic [7:0] byte_c;
  logic [3:0] code_c;

  always_comb begin
    kind_c = KIND_TX;
    byte_c = 8'd0;
    code_c = ST_OK;
    n_last = 2'd0;
    case (head_job.op)
      JOB_HDR: begin
        n_last = 2'd3;
        case (cnt)
          2'd0:    byte_c = PKT_COMMAND;
          2'd1:    byte_c = head_job.b0;
          2'd2:    byte_c = head_job.b1;
          default: byte_c = head_job.b2;
        endcase
      end
      JOB_TX: byte_c = head_job.b0;
      JOB_RET: begin
        kind_c = KIND_RET;
        byte_c = head_job.b0;
      end
      JOB_RET_FIN: begin
        n_last = 2'd1;
        if (cnt == 2'd0) begin
          kind_c = KIND_RET;
          byte_c = head_job.b0;
        end else kind_c = KIND_DONE;
      end
      default: begin
        kind_c = KIND_DONE;
        code_c = head_job.code;
      end
    endcase
  end

  assign is_last = cnt == n_last;
  assign load    = !res.valid || res.ready;
  assign take    = load && head_valid;
  assign pop     = take && is_last;

  always_ff @(posedge clk) begin
    if (rst) begin
      res.valid <= 1'b0;
      cnt       <= '0;
    end else begin
      if (load) res.valid <= head_valid;
      if (take) cnt <= is_last ? 2'd0 : cnt + 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      res.kind        <= kind_c;
      res.out_byte    <= byte_c;
      res.status_code <= code_c;
      res.last        <= is_last;
    end
  end

  // mid-job counter only for multi-result jobs, and only while a head job is present
  a_cnt_head: assert property (@(posedge clk) disable iff (rst)
    cnt != 2'd0 |-> head_valid && (head_job.op == JOB_HDR || head_job.op == JOB_RET_FIN))
    else $error("result counter advanced on a single-result job");
  a_cnt_range: assert property (@(posedge clk) disable iff (rst)
    cnt > 2'd1 |-> head_job.op == JOB_HDR)
    else $error("counter beyond job length");
  a_done_last: assert property (@(posedge clk) disable iff (rst)
    res.valid && res.kind == KIND_DONE |-> res.last)
    else $error("finish result not marked last");
  a_pop_last: assert property (@(posedge clk) disable iff (rst)
    pop |=> res.valid && res.last)
    else $error("job retired without a last result");

endmodule

FILE: dv/hcice_event_checker.sv
// ----------------------------------------------------------------------------
// hcice_event_checker
// Watches the request and result channels of the HCI command/event engine,
// predicts every result from the accepted requests and compares them in order.
// ----------------------------------------------------------------------------
module hcice_event_checker (
  input  logic        clk,
  input  logic        rst,
  hcice_req_if        req,
  hcice_res_if        res,
  output int          owed,
  output int          fail_count
);
  import hcice_pkg::*;

  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] out_byte;
    logic [3:0] status_code;
    logic       last;
  } hci_result_t;

  phase_t      phase;
  logic [15:0] saved_op;
  logic [7:0]  pay_left;
  logic [7:0]  ret_len;
  logic [7:0]  ret_left;
  hci_result_t owed_results[$];
  int          mism;

  task automatic flag_mismatch(input string msg);
    mism++;
    $display("%0t mismatch: %s", $time, msg);
  endtask

  task automatic emit(input logic [1:0] kind, input logic [7:0] b, input logic [3:0] code);
    owed_results.push_back({kind, b, code, 1'b0});
  endtask

  task automatic close_cmd(input logic [3:0] code);
    phase = PH_IDLE;
    emit(KIND_DONE, 8'h00, code);
  endtask

  // One accepted request: advance the framer/parser and queue what it produces.
  task automatic hci_step(input logic [1:0] mode, input logic [15:0] opc,
                          input logic [7:0] plen, input logic [7:0] rlen,
                          input logic [7:0] b);
    int          base;
    logic [7:0]  lo;
    logic [7:0]  hi;
    hci_result_t tail;
    base = owed_results.size();
    lo = saved_op[7:0];
    hi = saved_op[15:8];
    case (mode)
      MODE_START: begin
        saved_op = opc;
        pay_left = plen;
        ret_len  = rlen;
        ret_left = 8'h00;
        emit(KIND_TX, PKT_COMMAND, ST_OK);
        emit(KIND_TX, opc[7:0], ST_OK);
        emit(KIND_TX, opc[15:8], ST_OK);
        emit(KIND_TX, plen, ST_OK);
        phase = (plen != 8'h00) ? PH_SEND : PH_TYPE;
      end
      MODE_PAYLOAD: begin
        if (phase == PH_SEND) begin
          emit(KIND_TX, b, ST_OK);
          pay_left = pay_left - 8'd1;
          if (pay_left == 8'h00) phase = PH_TYPE;
        end
      end
      MODE_RX: begin
        case (phase)
          PH_TYPE: if (b != PKT_EVENT) close_cmd(ST_BAD_TYPE); else phase = PH_CODE;
          PH_CODE: begin
            if (b == EVT_STATUS) phase = PH_S_LEN;
            else if (b == EVT_COMPLETE) phase = PH_C_LEN;
            else close_cmd(ST_BAD_EVENT);
          end
          PH_S_LEN:  if (b != CS_LEN) close_cmd(ST_CS_LEN); else phase = PH_S_STAT;
          PH_S_STAT: if (b != 8'h00) close_cmd(ST_CS_STATUS); else phase = PH_S_NUM;
          PH_S_NUM:  if (b == 8'h00) close_cmd(ST_CS_NUM); else phase = PH_S_OPL;
          PH_S_OPL:  if (b != lo) close_cmd(ST_CS_OPL); else phase = PH_S_OPH;
          PH_S_OPH:  close_cmd((b != hi) ? ST_CS_OPH : ST_OK);
          PH_C_LEN: begin
            if ({1'b0, b} != 9'd4 + {1'b0, ret_len}) close_cmd(ST_CC_LEN);
            else phase = PH_C_NUM;
          end
          PH_C_NUM:  if (b == 8'h00) close_cmd(ST_CC_NUM); else phase = PH_C_OPL;
          PH_C_OPL:  if (b != lo) close_cmd(ST_CC_OPL); else phase = PH_C_OPH;
          PH_C_OPH:  if (b != hi) close_cmd(ST_CC_OPH); else phase = PH_C_STAT;
          PH_C_STAT: begin
            if (b != 8'h00) close_cmd(ST_CC_STATUS);
            else if (ret_len == 8'h00) close_cmd(ST_OK);
            else begin
              ret_left = ret_len;
              phase = PH_C_RET;
            end
          end
          PH_C_RET: begin
            emit(KIND_RET, b, ST_OK);
            ret_left = ret_left - 8'd1;
            if (ret_left == 8'h00) close_cmd(ST_OK);
          end
          default: ;
        endcase
      end
      default: ;
    endcase
    if (owed_results.size() > base) begin
      tail = owed_results.pop_back();
      tail.last = 1'b1;
      owed_results.push_back(tail);
    end
  endtask

  always @(posedge clk) begin
    hci_result_t got;
    hci_result_t want;
    if (rst) begin
      phase    = PH_IDLE;
      saved_op = 16'h0000;
      pay_left = 8'h00;
      ret_len  = 8'h00;
      ret_left = 8'h00;
      owed_results.delete();
    end else begin
      // requests first: a result can never precede the request that caused it
      if (req.valid && req.ready)
        hci_step(req.mode, req.opcode, req.param_len, req.return_len, req.data_byte);
      if (res.valid && res.ready) begin
        got = {res.kind, res.out_byte, res.status_code, res.last};
        if (owed_results.size() == 0) begin
          flag_mismatch($sformatf("unexpected result kind %0d byte %02h status %0d last %0b",
                                  got.kind, got.out_byte, got.status_code, got.last));
        end else begin
          want = owed_results.pop_front();
          if (got.kind != want.kind)
            flag_mismatch($sformatf("kind %0d, want %0d", got.kind, want.kind));
          if (got.out_byte != want.out_byte)
            flag_mismatch($sformatf("out_byte %02h, want %02h", got.out_byte, want.out_byte));
          if (got.status_code != want.status_code)
            flag_mismatch($sformatf("status_code %0d, want %0d",
                                    got.status_code, want.status_code));
          if (got.last != want.last)
            flag_mismatch($sformatf("last %0b, want %0b", got.last, want.last));
        end
      end
    end
    owed       <= owed_results.size();
    fail_count <= mism;
  end

endmodule

FILE: dv/hci_command_event_engine_top_tb.sv
// ----------------------------------------------------------------------------
// hci_command_event_engine_top_tb
// Drives framed HCI commands, payload and controller replies into the engine
// with random gaps and back-pressure; the checker predicts and compares.
// ----------------------------------------------------------------------------
module hci_command_event_engine_top_tb;
  import hcice_pkg::*;

  localparam logic [1:0] MODE_NONE = 2'd3;

  logic clk;
  logic rst;
  int   owed;
  int   fail_count;
  int   sent;
  bit   tx_lazy   = 1'b1;
  bit   tx_rush   = 1'b0;
  bit   rx_lazy   = 1'b1;
  bit   hold_long = 1'b0;

  hcice_req_if req_ch ();
  hcice_res_if res_ch ();

  hci_command_event_engine_top dut (
    .clk (clk),
    .rst (rst),
    .req (req_ch),
    .res (res_ch)
  );

  hcice_event_checker chk (
    .clk        (clk),
    .rst        (rst),
    .req        (req_ch),
    .res        (res_ch),
    .owed       (owed),
    .fail_count (fail_count)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  initial begin
    #1_000_000;
    $display("[FAIL] regression broken");
    $finish;
  end

  task automatic push_req(input logic [1:0] mode, input logic [15:0] opc,
                          input logic [7:0] plen, input logic [7:0] rlen,
                          input logic [7:0] b);
    int gap;
    gap = (tx_lazy && !tx_rush) ? $urandom_range(0, 19) : 0;
    if ($urandom_range(0, 29) == 0) tx_lazy = !tx_lazy;
    if (gap > 0) begin
      req_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req_ch.valid      <= 1'b1;
    req_ch.mode       <= mode;
    req_ch.opcode     <= opc;
    req_ch.param_len  <= plen;
    req_ch.return_len <= rlen;
    req_ch.data_byte  <= b;
    do @(posedge clk); while (!req_ch.ready);
    sent++;
  endtask

  task automatic put_byte(input logic [1:0] mode, input logic [7:0] b);
    push_req(mode, 16'($urandom), 8'($urandom), 8'($urandom), b);
  endtask

  task automatic drain();
    req_ch.valid <= 1'b0;
    do @(posedge clk); while (owed != 0);
  endtask

  // One command with a reply that is mostly well formed; sometimes a header
  // byte is corrupted, the reply is cut short, or noise follows.
  task automatic run_command();
    logic [15:0] opc;
    logic [7:0]  plen;
    logic [7:0]  rlen;
    logic [7:0]  ev[$];
    int          pos;
    int          i;
    case ($urandom_range(0, 7))
      0:       opc = 16'h0000;
      1:       opc = 16'hFFFF;
      default: opc = 16'($urandom);
    endcase
    plen = ($urandom_range(0, 29) == 0) ? 8'($urandom) : 8'($urandom_range(0, 5));
    rlen = ($urandom_range(0, 11) == 0) ? 8'($urandom) : 8'($urandom_range(0, 4));
    push_req(MODE_START, opc, plen, rlen, 8'($urandom));
    for (i = 0; i < plen; i++) begin
      if ($urandom_range(0, 9) == 0) put_byte(MODE_RX, 8'($urandom));
      put_byte(MODE_PAYLOAD, 8'($urandom));
    end
    ev.push_back(PKT_EVENT);
    if ((rlen > 8'd8 && rlen <= 8'd251) || $urandom_range(0, 2) == 0) begin
      ev.push_back(EVT_STATUS);
      ev.push_back(CS_LEN);
      ev.push_back(8'h00);
      ev.push_back(8'($urandom_range(1, 255)));
      ev.push_back(opc[7:0]);
      ev.push_back(opc[15:8]);
    end else begin
      ev.push_back(EVT_COMPLETE);
      ev.push_back(8'(rlen + 8'd4));
      ev.push_back(8'($urandom_range(1, 255)));
      ev.push_back(opc[7:0]);
      ev.push_back(opc[15:8]);
      ev.push_back(8'h00);
      for (i = 0; i < rlen && rlen <= 8'd251; i++) ev.push_back(8'($urandom));
    end
    if ($urandom_range(0, 3) == 0) begin
      pos = $urandom_range(0, 6);
      ev[pos] = ev[pos] ^ 8'($urandom_range(1, 255));
      if ($urandom_range(0, 3) != 0)
        while (ev.size() > pos + 1) void'(ev.pop_back());
    end else if ($urandom_range(0, 9) == 0) begin
      pos = $urandom_range(0, ev.size() - 1);
      while (ev.size() > pos) void'(ev.pop_back());
    end
    foreach (ev[k]) put_byte(MODE_RX, ev[k]);
    if ($urandom_range(0, 4) == 0) begin
      repeat ($urandom_range(1, 3)) begin
        case ($urandom_range(0, 2))
          0:       put_byte(MODE_NONE, 8'($urandom));
          1:       put_byte(MODE_PAYLOAD, 8'($urandom));
          default: put_byte(MODE_RX, 8'($urandom));
        endcase
      end
    end
  endtask

  // result side: random stalls, plus one long hold-off on request
  initial begin
    int gap;
    res_ch.ready <= 1'b0;
    while (rst !== 1'b0) @(posedge clk);
    forever begin
      if (hold_long) begin
        gap = 400;
        hold_long = 1'b0;
      end else begin
        gap = rx_lazy ? $urandom_range(0, 19) : 0;
      end
      if ($urandom_range(0, 49) == 0) rx_lazy = !rx_lazy;
      if (gap > 0) begin
        res_ch.ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      res_ch.ready <= 1'b1;
      do @(posedge clk); while (!res_ch.valid);
    end
  end

  initial begin
    int i;
    int plen;
    rst                <= 1'b1;
    req_ch.valid       <= 1'b0;
    req_ch.mode        <= MODE_START;
    req_ch.opcode      <= 16'h0000;
    req_ch.param_len   <= 8'h00;
    req_ch.return_len  <= 8'h00;
    req_ch.data_byte   <= 8'h00;
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // Command Complete, all-ones opcode, no return bytes
    push_req(MODE_START, 16'hFFFF, 8'h00, 8'h00, 8'h00);
    put_byte(MODE_RX, PKT_EVENT);
    put_byte(MODE_RX, EVT_COMPLETE);
    put_byte(MODE_RX, CS_LEN);
    put_byte(MODE_RX, 8'hFF);
    put_byte(MODE_RX, 8'hFF);
    put_byte(MODE_RX, 8'hFF);
    put_byte(MODE_RX, 8'h00);
    // Command Status, zero opcode, payload extremes, maximum return length
    push_req(MODE_START, 16'h0000, 8'h02, 8'd251, 8'hFF);
    put_byte(MODE_PAYLOAD, 8'h00);
    put_byte(MODE_PAYLOAD, 8'hFF);
    put_byte(MODE_RX, PKT_EVENT);
    put_byte(MODE_RX, EVT_STATUS);
    put_byte(MODE_RX, CS_LEN);
    put_byte(MODE_RX, 8'h00);
    put_byte(MODE_RX, 8'h01);
    put_byte(MODE_RX, 8'h00);
    put_byte(MODE_RX, 8'h00);
    // ignored while idle
    put_byte(MODE_NONE, 8'hA5);
    put_byte(MODE_PAYLOAD, 8'h5A);
    put_byte(MODE_RX, PKT_EVENT);
    // return length past 251 cannot match any length byte
    push_req(MODE_START, 16'h1234, 8'h00, 8'hFF, 8'h00);
    put_byte(MODE_RX, PKT_EVENT);
    put_byte(MODE_RX, EVT_COMPLETE);
    put_byte(MODE_RX, 8'h03);

    // long payload against a stalled receiver: fills the job queue
    hold_long = 1'b1;
    tx_rush   = 1'b1;
    plen      = $urandom_range(140, 200);
    push_req(MODE_START, 16'($urandom), 8'(plen), 8'($urandom_range(0, 4)), 8'h00);
    for (i = 0; i < plen; i++) put_byte(MODE_PAYLOAD, 8'($urandom));
    tx_rush = 1'b0;
    drain();

    while (sent < 380) begin
      run_command();
      if ($urandom_range(0, 7) == 0) drain();
    end

    drain();
    repeat (20) @(posedge clk);
    if (fail_count == 0) $display("[ OK ] regression clean");
    else $display("[FAIL] regression broken");
    $finish;
  end

endmodule

FILE: filelist.f
hw/rtl/hcice_pkg.sv
hw/rtl/hcice_if.sv
hw/rtl/hcice_front.sv
hw/rtl/hcice_queue.sv
hw/rtl/hcice_back.sv
hw/rtl/hci_command_event_engine_top.sv
dv/hcice_event_checker.sv
dv/hci_command_event_engine_top_tb.sv
